### design/mflg_pkg.sv
package mflg_pkg;

   localparam int NODES     = 1024;
   localparam int NODE_W    = 10;
   localparam int ARC_SLOTS = 8194;
   localparam int ARC_W     = 14;
   localparam int CAP_W     = 31;
   localparam int LVL_W     = 11;
   localparam int FLOW_W    = 43;
   localparam int QPTR_W    = 11;
   localparam int CSR_IDX_W = 1;

   localparam logic [ARC_W-1:0]  ARC_ROOM_MAX = ARC_W'(ARC_SLOTS - 3);
   localparam logic [CAP_W-1:0]  AUG_LIMIT    = CAP_W'(32'h3f3f3f3f);

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SINK   = 1'b1;

   typedef struct packed {
      logic [ARC_W-1:0]  next;
      logic [NODE_W-1:0] target;
   } arc_ent_type;

   typedef struct packed {
      logic [LVL_W-1:0]  lvl;
      logic [NODE_W-1:0] node;
   } qent_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [ARC_W-1:0]  arc;
      logic [CAP_W-1:0]  rest;
      logic [CAP_W-1:0]  flow;
      logic [LVL_W-1:0]  lvl;
   } frame_type;

   typedef enum logic [23:0] {
      ST_CLEAR     = 24'h000001,
      ST_LOAD      = 24'h000002,
      ST_E_FWD     = 24'h000004,
      ST_E_REV     = 24'h000008,
      ST_LV_CLR    = 24'h000010,
      ST_B_INIT    = 24'h000020,
      ST_BQ_POP    = 24'h000040,
      ST_BQ_WAIT   = 24'h000080,
      ST_BA_FIRST  = 24'h000100,
      ST_BA_CHK    = 24'h000200,
      ST_BA_RD     = 24'h000400,
      ST_BA_LV     = 24'h000800,
      ST_AUG_START = 24'h001000,
      ST_AUG_INIT  = 24'h002000,
      ST_D_LOOP    = 24'h004000,
      ST_D_RD      = 24'h008000,
      ST_D_LV      = 24'h010000,
      ST_D_T1      = 24'h020000,
      ST_D_PUSH    = 24'h040000,
      ST_D_RET     = 24'h080000,
      ST_D_POP     = 24'h100000,
      ST_D_P1      = 24'h200000,
      ST_D_P2      = 24'h400000,
      ST_DONE      = 24'h800000
   } state_type;

endpackage

### design/mflg_ram.sv
module mflg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/max_flow_level_graph_solver.sv
// channel   direction  ports
// req       in         req_valid/req_ready, from_node, to_node, capacity, last_edge
// rsp       out        rsp_valid/rsp_ready, max_flow, edge_overflow
// csr       in         csr_valid/csr_ready, csr_index, csr_data
// an edge: one first_arc read, then forward and reverse arc writes
// a solve round: level clear, bfs over the arcs of each dequeued node,
// then dfs over arc steps and frame returns
// after reset and after each result a first_arc clear runs, with req_ready low
// req_ready is low from the last edge until the result is loaded into the output register
// the result register holds until taken; loading of the next graph overlaps with it
module max_flow_level_graph_solver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mflg_pkg::NODE_W-1:0]         req_from_node,
   input  logic [mflg_pkg::NODE_W-1:0]         req_to_node,
   input  logic [mflg_pkg::CAP_W-1:0]          req_capacity,
   input  logic                                req_last_edge,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mflg_pkg::FLOW_W-1:0]         rsp_max_flow,
   output logic                                rsp_edge_overflow,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mflg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mflg_pkg::NODE_W-1:0]         csr_data
);

   localparam int NW = mflg_pkg::NODE_W;
   localparam int AW = mflg_pkg::ARC_W;
   localparam int CW = mflg_pkg::CAP_W;
   localparam int LW = mflg_pkg::LVL_W;
   localparam int FW = mflg_pkg::FLOW_W;
   localparam int QW = mflg_pkg::QPTR_W;

   mflg_pkg::state_type state_ff, state_in;

   logic [NW-1:0] src_ff, src_in, snk_ff, snk_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [FW-1:0] total_ff, total_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [NW-1:0] e_from_ff, e_from_in, e_to_ff, e_to_in;
   logic [CW-1:0] e_cap_ff, e_cap_in;
   logic          e_last_ff, e_last_in;
   logic [QW-1:0] qh_ff, qh_in, qt_ff, qt_in;
   logic [LW-1:0] lnow_ff, lnow_in;
   logic [AW-1:0] arc_ff, arc_in;
   logic [NW-1:0] nb_ff, nb_in;
   logic [AW-1:0] nxt_ff, nxt_in;
   logic [CW-1:0] res_ff, res_in;
   logic [NW-1:0] sp_ff, sp_in;
   logic [NW-1:0] fn_ff, fn_in;
   logic [AW-1:0] fa_ff, fa_in;
   logic [CW-1:0] fr_ff, fr_in, fflow_ff, fflow_in;
   logic [LW-1:0] flvl_ff, flvl_in;
   logic [CW-1:0] amt_ff, amt_in, got_ff, got_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] rsp_flow_ff, rsp_flow_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic                 fa_we, fa_re;
   logic [NW-1:0]        fa_wa, fa_ra;
   logic [AW-1:0]        fa_wd, fa_rd;
   logic                 am_we, am_re;
   logic [AW-1:0]        am_wa, am_ra;
   mflg_pkg::arc_ent_type am_wd, am_rd;
   logic                 rs_we, rs_re;
   logic [AW-1:0]        rs_wa, rs_ra;
   logic [CW-1:0]        rs_wd, rs_rd;
   logic                 lv_we, lv_re;
   logic [NW-1:0]        lv_wa, lv_ra;
   logic [LW-1:0]        lv_wd, lv_rd;
   logic                 q_we, q_re;
   logic [NW-1:0]        q_wa, q_ra;
   mflg_pkg::qent_type   q_wd, q_rd;
   logic                 fr_we, fr_re;
   logic [NW-1:0]        fm_wa, fm_ra;
   mflg_pkg::frame_type  fm_wd, fm_rd;

   logic          req_fire;
   logic [AW-1:0] arc_a, arc_b;
   logic [CW-1:0] amt, got;
   logic          dfs_ok;
   mflg_pkg::state_type solve_state;

   assign req_ready = (state_ff == mflg_pkg::ST_LOAD);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign arc_a     = cnt_ff + AW'(1);
   assign arc_b     = cnt_ff + AW'(2);
   assign amt       = (fr_ff < res_ff) ? fr_ff : res_ff;
   assign got       = fflow_ff - fr_ff;
   assign dfs_ok    = (res_ff != '0) && (lv_rd == flvl_ff + LW'(1));
   assign solve_state = (src_ff == snk_ff) ? mflg_pkg::ST_DONE : mflg_pkg::ST_LV_CLR;

   always_comb begin
      state_in = state_ff;
      src_in = src_ff;  snk_in = snk_ff;  cnt_in = cnt_ff;  ovf_in = ovf_ff;
      total_in = total_ff;  clr_in = clr_ff;
      e_from_in = e_from_ff;  e_to_in = e_to_ff;  e_cap_in = e_cap_ff;  e_last_in = e_last_ff;
      qh_in = qh_ff;  qt_in = qt_ff;  lnow_in = lnow_ff;  arc_in = arc_ff;
      nb_in = nb_ff;  nxt_in = nxt_ff;  res_in = res_ff;  sp_in = sp_ff;
      fn_in = fn_ff;  fa_in = fa_ff;  fr_in = fr_ff;  fflow_in = fflow_ff;  flvl_in = flvl_ff;
      amt_in = amt_ff;  got_in = got_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_flow_in = rsp_flow_ff;  rsp_ovf_in = rsp_ovf_ff;

      fa_we = 1'b0;  fa_wa = '0;  fa_wd = '0;  fa_re = 1'b0;  fa_ra = '0;
      am_we = 1'b0;  am_wa = '0;  am_wd = '0;  am_re = 1'b0;  am_ra = '0;
      rs_we = 1'b0;  rs_wa = '0;  rs_wd = '0;  rs_re = 1'b0;  rs_ra = '0;
      lv_we = 1'b0;  lv_wa = '0;  lv_wd = '0;  lv_re = 1'b0;  lv_ra = '0;
      q_we  = 1'b0;  q_wa  = '0;  q_wd  = '0;  q_re  = 1'b0;  q_ra  = '0;
      fr_we = 1'b0;  fm_wa = '0;  fm_wd = '0;  fr_re = 1'b0;  fm_ra = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         unique case (csr_index)
            mflg_pkg::CSR_SOURCE: src_in = csr_data;
            mflg_pkg::CSR_SINK:   snk_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         mflg_pkg::ST_CLEAR: begin
            fa_we = 1'b1;  fa_wa = clr_ff;
            clr_in = clr_ff + NW'(1);
            if (clr_ff == '1) begin
               state_in = mflg_pkg::ST_LOAD;
            end
         end
         mflg_pkg::ST_LOAD: begin
            if (req_fire) begin
               e_from_in = req_from_node;  e_to_in = req_to_node;
               e_cap_in = req_capacity;    e_last_in = req_last_edge;
               if (cnt_ff <= mflg_pkg::ARC_ROOM_MAX) begin
                  fa_re = 1'b1;  fa_ra = req_from_node;
                  state_in = mflg_pkg::ST_E_FWD;
               end else begin
                  ovf_in = 1'b1;
                  if (req_last_edge) begin
                     state_in = solve_state;
                     clr_in = '0;
                  end
               end
            end
         end
         mflg_pkg::ST_E_FWD: begin
            am_we = 1'b1;  am_wa = arc_a;  am_wd = '{next: fa_rd, target: e_to_ff};
            rs_we = 1'b1;  rs_wa = arc_a;  rs_wd = e_cap_ff;
            fa_we = 1'b1;  fa_wa = e_from_ff;  fa_wd = arc_a;
            fa_re = 1'b1;  fa_ra = e_to_ff;
            state_in = mflg_pkg::ST_E_REV;
         end
         mflg_pkg::ST_E_REV: begin
            am_we = 1'b1;  am_wa = arc_b;
            am_wd = '{next: (e_to_ff == e_from_ff) ? arc_a : fa_rd, target: e_from_ff};
            rs_we = 1'b1;  rs_wa = arc_b;  rs_wd = '0;
            fa_we = 1'b1;  fa_wa = e_to_ff;  fa_wd = arc_b;
            cnt_in = arc_b;
            if (e_last_ff) begin
               state_in = solve_state;
               clr_in = '0;
            end else begin
               state_in = mflg_pkg::ST_LOAD;
            end
         end
         mflg_pkg::ST_LV_CLR: begin
            lv_we = 1'b1;  lv_wa = clr_ff;
            clr_in = clr_ff + NW'(1);
            if (clr_ff == '1) begin
               state_in = mflg_pkg::ST_B_INIT;
            end
         end
         mflg_pkg::ST_B_INIT: begin
            lv_we = 1'b1;  lv_wa = src_ff;  lv_wd = LW'(1);
            q_we = 1'b1;   q_wa = '0;       q_wd = '{lvl: LW'(1), node: src_ff};
            qh_in = '0;  qt_in = QW'(1);
            state_in = mflg_pkg::ST_BQ_POP;
         end
         mflg_pkg::ST_BQ_POP: begin
            if (qh_ff == qt_ff) begin
               state_in = mflg_pkg::ST_DONE;
            end else begin
               q_re = 1'b1;  q_ra = qh_ff[NW-1:0];
               qh_in = qh_ff + QW'(1);
               state_in = mflg_pkg::ST_BQ_WAIT;
            end
         end
         mflg_pkg::ST_BQ_WAIT: begin
            lnow_in = q_rd.lvl;
            fa_re = 1'b1;  fa_ra = q_rd.node;
            state_in = mflg_pkg::ST_BA_FIRST;
         end
         mflg_pkg::ST_BA_FIRST: begin
            arc_in = fa_rd;
            state_in = mflg_pkg::ST_BA_CHK;
         end
         mflg_pkg::ST_BA_CHK: begin
            if (arc_ff == '0) begin
               state_in = mflg_pkg::ST_BQ_POP;
            end else begin
               am_re = 1'b1;  am_ra = arc_ff;
               rs_re = 1'b1;  rs_ra = arc_ff;
               state_in = mflg_pkg::ST_BA_RD;
            end
         end
         mflg_pkg::ST_BA_RD: begin
            nb_in = am_rd.target;  nxt_in = am_rd.next;  res_in = rs_rd;
            lv_re = 1'b1;  lv_ra = am_rd.target;
            state_in = mflg_pkg::ST_BA_LV;
         end
         mflg_pkg::ST_BA_LV: begin
            arc_in = nxt_ff;
            state_in = mflg_pkg::ST_BA_CHK;
            if (res_ff != '0 && lv_rd == '0) begin
               lv_we = 1'b1;  lv_wa = nb_ff;  lv_wd = lnow_ff + LW'(1);
               if (qt_ff < QW'(mflg_pkg::NODES)) begin
                  q_we = 1'b1;  q_wa = qt_ff[NW-1:0];
                  q_wd = '{lvl: lnow_ff + LW'(1), node: nb_ff};
                  qt_in = qt_ff + QW'(1);
               end
               if (nb_ff == snk_ff) begin
                  state_in = mflg_pkg::ST_AUG_START;
               end
            end
         end
         mflg_pkg::ST_AUG_START: begin
            fa_re = 1'b1;  fa_ra = src_ff;
            sp_in = '0;
            state_in = mflg_pkg::ST_AUG_INIT;
         end
         mflg_pkg::ST_AUG_INIT: begin
            fn_in = src_ff;  fa_in = fa_rd;
            fr_in = mflg_pkg::AUG_LIMIT;  fflow_in = mflg_pkg::AUG_LIMIT;
            flvl_in = LW'(1);
            state_in = mflg_pkg::ST_D_LOOP;
         end
         mflg_pkg::ST_D_LOOP: begin
            if (fa_ff == '0 || fr_ff == '0) begin
               state_in = mflg_pkg::ST_D_RET;
            end else begin
               am_re = 1'b1;  am_ra = fa_ff;
               rs_re = 1'b1;  rs_ra = fa_ff;
               state_in = mflg_pkg::ST_D_RD;
            end
         end
         mflg_pkg::ST_D_RD: begin
            nb_in = am_rd.target;  nxt_in = am_rd.next;  res_in = rs_rd;
            lv_re = 1'b1;  lv_ra = am_rd.target;
            state_in = mflg_pkg::ST_D_LV;
         end
         mflg_pkg::ST_D_LV: begin
            if (dfs_ok && nb_ff == snk_ff) begin
               rs_we = 1'b1;  rs_wa = fa_ff;  rs_wd = res_ff - amt;
               rs_re = 1'b1;  rs_ra = fa_ff ^ AW'(1);
               fr_in = fr_ff - amt;
               amt_in = amt;
               state_in = mflg_pkg::ST_D_T1;
            end else if (dfs_ok && sp_ff != '1) begin
               fr_we = 1'b1;  fm_wa = sp_ff;
               fm_wd = '{node: fn_ff, arc: fa_ff, rest: fr_ff, flow: fflow_ff, lvl: flvl_ff};
               sp_in = sp_ff + NW'(1);
               fn_in = nb_ff;  fr_in = amt;  fflow_in = amt;
               flvl_in = flvl_ff + LW'(1);
               fa_re = 1'b1;  fa_ra = nb_ff;
               state_in = mflg_pkg::ST_D_PUSH;
            end else begin
               fa_in = nxt_ff;
               state_in = mflg_pkg::ST_D_LOOP;
            end
         end
         mflg_pkg::ST_D_T1: begin
            rs_we = 1'b1;  rs_wa = fa_ff ^ AW'(1);  rs_wd = rs_rd + amt_ff;
            fa_in = nxt_ff;
            state_in = mflg_pkg::ST_D_LOOP;
         end
         mflg_pkg::ST_D_PUSH: begin
            fa_in = fa_rd;
            state_in = mflg_pkg::ST_D_LOOP;
         end
         mflg_pkg::ST_D_RET: begin
            if (sp_ff == '0) begin
               if (got == '0) begin
                  clr_in = '0;
                  state_in = mflg_pkg::ST_LV_CLR;
               end else begin
                  total_in = total_ff + FW'(got);
                  state_in = mflg_pkg::ST_AUG_START;
               end
            end else begin
               fr_re = 1'b1;  fm_ra = sp_ff - NW'(1);
               sp_in = sp_ff - NW'(1);
               got_in = got;
               if (got == '0) begin
                  lv_we = 1'b1;  lv_wa = fn_ff;  lv_wd = '0;
               end
               state_in = mflg_pkg::ST_D_POP;
            end
         end
         mflg_pkg::ST_D_POP: begin
            fn_in = fm_rd.node;  fa_in = fm_rd.arc;  fr_in = fm_rd.rest;
            fflow_in = fm_rd.flow;  flvl_in = fm_rd.lvl;
            am_re = 1'b1;  am_ra = fm_rd.arc;
            rs_re = 1'b1;  rs_ra = fm_rd.arc;
            state_in = mflg_pkg::ST_D_P1;
         end
         mflg_pkg::ST_D_P1: begin
            rs_we = 1'b1;  rs_wa = fa_ff;  rs_wd = rs_rd - got_ff;
            rs_re = 1'b1;  rs_ra = fa_ff ^ AW'(1);
            nxt_in = am_rd.next;
            fr_in = fr_ff - got_ff;
            state_in = mflg_pkg::ST_D_P2;
         end
         mflg_pkg::ST_D_P2: begin
            rs_we = 1'b1;  rs_wa = fa_ff ^ AW'(1);  rs_wd = rs_rd + got_ff;
            fa_in = nxt_ff;
            state_in = mflg_pkg::ST_D_LOOP;
         end
         mflg_pkg::ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_flow_in = total_ff;
               rsp_ovf_in = ovf_ff;
               cnt_in = AW'(1);
               total_in = '0;
               ovf_in = 1'b0;
               clr_in = '0;
               state_in = mflg_pkg::ST_CLEAR;
            end
         end
         default: state_in = mflg_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mflg_pkg::ST_CLEAR;
         src_ff <= '0;
         snk_ff <= NW'(1);
         cnt_ff <= AW'(1);
         ovf_ff <= 1'b0;
         total_ff <= '0;
         clr_ff <= '0;
         sp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         src_ff <= src_in;
         snk_ff <= snk_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         total_ff <= total_in;
         clr_ff <= clr_in;
         sp_ff <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_from_ff <= e_from_in;  e_to_ff <= e_to_in;  e_cap_ff <= e_cap_in;
      e_last_ff <= e_last_in;
      qh_ff <= qh_in;  qt_ff <= qt_in;  lnow_ff <= lnow_in;
      arc_ff <= arc_in;  nb_ff <= nb_in;  nxt_ff <= nxt_in;  res_ff <= res_in;
      fn_ff <= fn_in;  fa_ff <= fa_in;  fr_ff <= fr_in;  fflow_ff <= fflow_in;
      flvl_ff <= flvl_in;  amt_ff <= amt_in;  got_ff <= got_in;
      rsp_flow_ff <= rsp_flow_in;  rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_max_flow      = rsp_flow_ff;
   assign rsp_edge_overflow = rsp_ovf_ff;

   mflg_ram #(.WIDTH(AW), .DEPTH(mflg_pkg::NODES)) u_first_arc (
      .clock(clock), .wr_en(fa_we), .wr_addr(fa_wa), .wr_data(fa_wd),
      .rd_en(fa_re), .rd_addr(fa_ra), .rd_data(fa_rd)
   );

   mflg_ram #(.WIDTH($bits(mflg_pkg::arc_ent_type)), .DEPTH(mflg_pkg::ARC_SLOTS)) u_arc (
      .clock(clock), .wr_en(am_we), .wr_addr(am_wa), .wr_data(am_wd),
      .rd_en(am_re), .rd_addr(am_ra), .rd_data(am_rd)
   );

   mflg_ram #(.WIDTH(CW), .DEPTH(mflg_pkg::ARC_SLOTS)) u_residual (
      .clock(clock), .wr_en(rs_we), .wr_addr(rs_wa), .wr_data(rs_wd),
      .rd_en(rs_re), .rd_addr(rs_ra), .rd_data(rs_rd)
   );

   mflg_ram #(.WIDTH(LW), .DEPTH(mflg_pkg::NODES)) u_level (
      .clock(clock), .wr_en(lv_we), .wr_addr(lv_wa), .wr_data(lv_wd),
      .rd_en(lv_re), .rd_addr(lv_ra), .rd_data(lv_rd)
   );

   mflg_ram #(.WIDTH($bits(mflg_pkg::qent_type)), .DEPTH(mflg_pkg::NODES)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_en(q_re), .rd_addr(q_ra), .rd_data(q_rd)
   );

   mflg_ram #(.WIDTH($bits(mflg_pkg::frame_type)), .DEPTH(mflg_pkg::NODES)) u_frame (
      .clock(clock), .wr_en(fr_we), .wr_addr(fm_wa), .wr_data(fm_wd),
      .rd_en(fr_re), .rd_addr(fm_ra), .rd_data(fm_rd)
   );

   a_cnt_odd: assert property (@(posedge clock) disable iff (reset) cnt_ff[0])
      else $error("arc count lost its odd alignment");

   a_stack_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mflg_pkg::ST_LOAD || state_ff == mflg_pkg::ST_DONE) |-> sp_ff == '0)
      else $error("frame stack not empty outside augmentation");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == mflg_pkg::ST_BQ_POP |-> qh_ff <= qt_ff)
      else $error("bfs queue head passed tail");

   a_no_req_in_solve: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_edge) |=> !req_ready)
      else $error("transaction accepted during solve");

endmodule

### tb/sv/max_flow_level_graph_solver_chk.sv
module max_flow_level_graph_solver_chk (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [mflg_pkg::NODE_W-1:0]    req_from_node,
   input  logic [mflg_pkg::NODE_W-1:0]    req_to_node,
   input  logic [mflg_pkg::CAP_W-1:0]     req_capacity,
   input  logic                           req_last_edge,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [mflg_pkg::FLOW_W-1:0]    rsp_max_flow,
   input  logic                           rsp_edge_overflow,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [mflg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mflg_pkg::NODE_W-1:0]    csr_data,
   output int                             errors,
   output int                             outstanding
);

   typedef struct packed {
      logic [mflg_pkg::FLOW_W-1:0] flow;
      logic                        ovf;
   } flow_result_type;

   flow_result_type flow_q[$];
   int              pend_cnt = 0;

   int unsigned src_node, snk_node;
   int unsigned arc_head [mflg_pkg::NODES];
   int unsigned arc_link [mflg_pkg::ARC_SLOTS];
   int unsigned arc_dst  [mflg_pkg::ARC_SLOTS];
   int unsigned arc_cap  [mflg_pkg::ARC_SLOTS];
   int unsigned node_depth [mflg_pkg::NODES];
   int unsigned arc_top;
   bit          dropped;
   int unsigned walk_q   [mflg_pkg::NODES];
   int unsigned stk_node [mflg_pkg::NODES];
   int unsigned stk_arc  [mflg_pkg::NODES];
   int unsigned stk_rest [mflg_pkg::NODES];
   int unsigned stk_flow [mflg_pkg::NODES];

   assign outstanding = pend_cnt;

   function automatic void clear_graph();
      foreach (arc_head[i]) arc_head[i] = 0;
      arc_top = 1;
      dropped = 0;
   endfunction

   function automatic void add_arc(int unsigned f, int unsigned t, int unsigned c);
      arc_top++;
      arc_dst[arc_top] = t;
      arc_cap[arc_top] = c;
      arc_link[arc_top] = arc_head[f];
      arc_head[f] = arc_top;
   endfunction

   function automatic bit build_depths();
      int unsigned qh, qt, now, a, nb;
      qh = 0;
      qt = 0;
      foreach (node_depth[i]) node_depth[i] = 0;
      node_depth[src_node] = 1;
      walk_q[qt++] = src_node;
      while (qh < qt) begin
         now = walk_q[qh++];
         for (a = arc_head[now]; a != 0; a = arc_link[a]) begin
            nb = arc_dst[a];
            if (arc_cap[a] != 0 && node_depth[nb] == 0) begin
               node_depth[nb] = node_depth[now] + 1;
               if (qt < mflg_pkg::NODES) walk_q[qt++] = nb;
               if (nb == snk_node) return 1;
            end
         end
      end
      return 0;
   endfunction

   function automatic int unsigned push_path();
      int unsigned sp, node, a, nb, amt, got;
      bit down;
      sp = 0;
      stk_node[0] = src_node;
      stk_arc[0] = arc_head[src_node];
      stk_rest[0] = 32'(mflg_pkg::AUG_LIMIT);
      stk_flow[0] = 32'(mflg_pkg::AUG_LIMIT);
      forever begin
         node = stk_node[sp];
         down = 0;
         while (stk_arc[sp] != 0 && stk_rest[sp] != 0) begin
            a = stk_arc[sp];
            nb = arc_dst[a];
            if (arc_cap[a] != 0 && node_depth[nb] == node_depth[node] + 1) begin
               amt = (stk_rest[sp] < arc_cap[a]) ? stk_rest[sp] : arc_cap[a];
               if (nb == snk_node) begin
                  arc_cap[a] -= amt;
                  arc_cap[a ^ 1] += amt;
                  stk_rest[sp] -= amt;
               end else if (sp + 1 < mflg_pkg::NODES) begin
                  sp++;
                  stk_node[sp] = nb;
                  stk_arc[sp] = arc_head[nb];
                  stk_rest[sp] = amt;
                  stk_flow[sp] = amt;
                  down = 1;
                  break;
               end
            end
            stk_arc[sp] = arc_link[a];
         end
         if (!down) begin
            got = stk_flow[sp] - stk_rest[sp];
            if (sp == 0) return got;
            sp--;
            a = stk_arc[sp];
            nb = arc_dst[a];
            if (got == 0) node_depth[nb] = 0;
            arc_cap[a] -= got;
            arc_cap[a ^ 1] += got;
            stk_rest[sp] -= got;
            stk_arc[sp] = arc_link[a];
         end
      end
   endfunction

   function automatic logic [mflg_pkg::FLOW_W-1:0] solve_flow();
      longint unsigned total;
      int unsigned f;
      total = 0;
      if (src_node == snk_node) return '0;
      while (build_depths()) begin
         f = push_path();
         while (f != 0) begin
            total += f;
            f = push_path();
         end
      end
      return total[mflg_pkg::FLOW_W-1:0];
   endfunction

   always @(posedge clock) begin
      flow_result_type r, got;
      int err_add;
      err_add = 0;
      if (reset) begin
         flow_q.delete();
         pend_cnt = 0;
         src_node = 0;
         snk_node = 1;
         clear_graph();
         errors <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == mflg_pkg::CSR_SOURCE) src_node = 32'(csr_data);
            else if (csr_index == mflg_pkg::CSR_SINK) snk_node = 32'(csr_data);
         end
         if (req_valid && req_ready) begin
            if (arc_top + 2 <= mflg_pkg::ARC_SLOTS - 1) begin
               add_arc(32'(req_from_node), 32'(req_to_node), 32'(req_capacity));
               add_arc(32'(req_to_node), 32'(req_from_node), 0);
            end else begin
               dropped = 1;
            end
            if (req_last_edge) begin
               r.flow = solve_flow();
               r.ovf = dropped;
               flow_q.push_back(r);
               pend_cnt++;
               clear_graph();
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.flow = rsp_max_flow;
            got.ovf = rsp_edge_overflow;
            if (flow_q.size() == 0) begin
               $display("%0t unexpected result transaction flow %0d overflow %0d",
                        $time, got.flow, got.ovf);
               err_add++;
            end else begin
               r = flow_q.pop_front();
               pend_cnt--;
               if (got.flow !== r.flow) begin
                  $display("%0t max_flow mismatch expected %0d actual %0d",
                           $time, r.flow, got.flow);
                  err_add++;
               end
               if (got.ovf !== r.ovf) begin
                  $display("%0t edge_overflow mismatch expected %0d actual %0d",
                           $time, r.ovf, got.ovf);
                  err_add++;
               end
            end
         end
         errors <= errors + err_add;
      end
   end

endmodule

### tb/sv/max_flow_level_graph_solver_tb.sv
module max_flow_level_graph_solver_tb;

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           req_valid = 0;
   logic                           req_ready;
   logic [mflg_pkg::NODE_W-1:0]    req_from_node = '0;
   logic [mflg_pkg::NODE_W-1:0]    req_to_node = '0;
   logic [mflg_pkg::CAP_W-1:0]     req_capacity = '0;
   logic                           req_last_edge = 0;
   logic                           rsp_valid;
   logic                           rsp_ready = 0;
   logic [mflg_pkg::FLOW_W-1:0]    rsp_max_flow;
   logic                           rsp_edge_overflow;
   logic                           csr_valid = 0;
   logic                           csr_ready;
   logic [mflg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mflg_pkg::NODE_W-1:0]    csr_data = '0;
   int                             errors, outstanding;
   int                             idle_pct = 0, stall_pct = 0;
   bit                             hold_req = 0, hold_ack = 0;
   int                             hold_cnt = 0;

   max_flow_level_graph_solver u_top (.*);

   max_flow_level_graph_solver_chk u_chk (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 0;
      end else if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_cnt <= 20000;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_edge(int unsigned f, int unsigned t, int unsigned c, bit last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_from_node <= mflg_pkg::NODE_W'(f);
      req_to_node <= mflg_pkg::NODE_W'(t);
      req_capacity <= mflg_pkg::CAP_W'(c);
      req_last_edge <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(logic [mflg_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= mflg_pkg::NODE_W'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int unsigned pick_node();
      return ($urandom_range(15) == 0) ? $urandom_range(1023) : $urandom_range(7);
   endfunction

   function automatic int unsigned pick_cap();
      case ($urandom_range(5))
         0: return 0;
         1: return 32'h7fffffff;
         2: return $urandom & 32'h7fffffff;
         3: return $urandom_range(32'h3f3f3f3f, 32'h3f3f3f41);
         default: return $urandom_range(20);
      endcase
   endfunction

   task automatic random_graph(output int n);
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
         send_edge(pick_node(), pick_node(), pick_cap(), i == n - 1);
   endtask

   initial begin
      int n, sent;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_edge(0, 1, 32'h7fffffff, 1);
      send_edge(0, 2, 5, 0);
      send_edge(2, 1, 3, 0);
      send_edge(0, 1, 0, 1);
      send_edge(3, 3, 9, 0);
      send_edge(0, 1, 0, 1);
      send_edge(0, 3, 32'h3f3f3f3f, 0);
      send_edge(0, 3, 32'h3f3f3f40, 0);
      send_edge(3, 1, 32'h7fffffff, 1);
      drain();
      write_csr(mflg_pkg::CSR_SOURCE, 1023);
      write_csr(mflg_pkg::CSR_SINK, 0);
      send_edge(1023, 512, 32'h7fffffff, 0);
      send_edge(512, 0, 32'h7fffffff, 0);
      send_edge(0, 1023, 7, 0);
      send_edge(1023, 0, 32'h2aaaaaaa, 1);
      drain();
      write_csr(mflg_pkg::CSR_SOURCE, 5);
      write_csr(mflg_pkg::CSR_SINK, 5);
      send_edge(5, 5, 100, 0);
      send_edge(5, 6, 100, 1);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         write_csr(mflg_pkg::CSR_SOURCE, $urandom_range(3));
         write_csr(mflg_pkg::CSR_SINK, $urandom_range(3));
         if (ph == 0) hold_req <= ~hold_req;
         sent = 0;
         while (sent < 295) begin
            random_graph(n);
            sent += n;
         end
         drain();
      end

      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("max_flow_level_graph_solver_tb: clean");
      else
         $display("max_flow_level_graph_solver_tb: errors");
      $finish;
   end

   initial begin
      #200000000;
      $display("max_flow_level_graph_solver_tb: errors");
      $finish;
   end

endmodule
